>>> src/csee_pkg.sv
// Package for the CIGAR soft-clip end extender.
// Holds character codes, fixed widths and the item structs.
// No dependencies.
package csee_pkg;

  // Default run-length width; the top level takes it as a parameter.
  localparam int unsigned RUN_BITS_DEF = 28;
  // Reference span accumulator width.
  localparam int unsigned SPAN_BITS = 30;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POS_W   = 31;
  localparam int unsigned COORD_W = 32;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_B = 8'h42;  // 'B'
  localparam logic [CHAR_W-1:0] CHAR_D = 8'h44;  // 'D'
  localparam logic [CHAR_W-1:0] CHAR_M = 8'h4D;  // 'M'
  localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;  // 'N'
  localparam logic [CHAR_W-1:0] CHAR_S = 8'h53;  // 'S'
  localparam logic [CHAR_W-1:0] CHAR_Y = 8'h59;  // 'Y'
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;  // 'Z'

  // Clip counter codes.
  localparam logic [1:0] CLIP_NONE  = 2'd0;
  localparam logic [1:0] CLIP_LEFT  = 2'd1;
  localparam logic [1:0] CLIP_SAT   = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  map_position;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] clipped_start;
    logic [COORD_W-1:0]        clipped_end;
  } out_item_t;

endpackage

>>> src/cigar_soft_clip_end_extender_core.sv
// Top level of the CIGAR soft-clip end extender.
// Parses CIGAR characters and gives clipped start/end per string.
// Depends on csee_pkg.
//
//  channel | signals                            | item
//  --------+------------------------------------+-------------------------------
//  in      | in_valid_i, in_ready_o, in_item_i  | one CIGAR char, position, last
//  out     | out_valid_o, out_ready_i, out_item_o | clipped start and end
//
// One character is taken per cycle while in_ready_o is high. Parse state updates in the accept cycle.
// A last character latches a snapshot into stage A (state clears at once);
// stage A then forms start/end into the output register.
// rst_ni clears all control and parse state asynchronously.
// Stage A and the output register stall together; in_ready_o drops only
// while both hold a string result that the sink has not taken.
module cigar_soft_clip_end_extender_core #(
  parameter int unsigned RUN_BITS = csee_pkg::RUN_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  csee_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output csee_pkg::out_item_t  out_item_o
);

  localparam int unsigned SpanW = csee_pkg::SPAN_BITS;
  localparam int unsigned PosW  = csee_pkg::POS_W;
  localparam int unsigned CW    = csee_pkg::COORD_W;
  // run * 10 + digit needs four more bits
  localparam int unsigned ProdW = RUN_BITS + 4;
  // span + run, one bit above the wider of the two
  localparam int unsigned SumW  = ((RUN_BITS > SpanW) ? RUN_BITS : SpanW) + 1;
  // end sum: pos + span + right fits in CW + 1 bits
  localparam int unsigned EndW  = CW + 1;

  // Parse state
  logic [RUN_BITS-1:0] run_q, run_d;
  logic                stop_q, stop_d;
  logic [SpanW-1:0]    span_q, span_d;
  logic [1:0]          clip_cnt_q, clip_cnt_d;
  logic [RUN_BITS-1:0] left_q, left_d;
  logic [RUN_BITS-1:0] right_q, right_d;

  // Stage A snapshot of a finished string
  logic                a_valid_q;
  logic [PosW-1:0]     a_pos_q;
  logic [SpanW-1:0]    a_span_q;
  logic [RUN_BITS-1:0] a_left_q;
  logic [RUN_BITS-1:0] a_right_q;

  // Output register
  logic                out_valid_q;
  csee_pkg::out_item_t out_q, out_d;

  logic in_acc, out_load, a_load;
  logic is_digit, is_op, is_span_op, is_clip;
  logic [ProdW-1:0]    prod;
  logic [SumW-1:0]     span_sum;
  logic [EndW-1:0]     start_diff, end_sum;

  // ---------------------------------------------------------------------
  // Handshake: output register loads when empty or being drained; stage A
  // moves on whenever the output register can load.
  // ---------------------------------------------------------------------
  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || out_load;
  assign in_acc     = in_valid_i && in_ready_o;
  assign a_load     = in_acc && in_item_i.last_char;

  // ---------------------------------------------------------------------
  // Character decode and next parse state
  // ---------------------------------------------------------------------
  always_comb begin
    is_digit   = in_item_i.char_code inside {[csee_pkg::CHAR_0 : csee_pkg::CHAR_9]};
    // operations are 'B'..'Y'; 'A' and 'Z' count as other characters
    is_op      = in_item_i.char_code inside {[csee_pkg::CHAR_B : csee_pkg::CHAR_Y]};
    is_span_op = (in_item_i.char_code == csee_pkg::CHAR_M) ||
                 (in_item_i.char_code == csee_pkg::CHAR_D) ||
                 (in_item_i.char_code == csee_pkg::CHAR_N);
    is_clip    = (in_item_i.char_code == csee_pkg::CHAR_S);

    // run * 8 + run * 2 + digit, digit is the low nibble of '0'..'9'
    prod = ({4'b0, run_q} << 3) + ({4'b0, run_q} << 1)
         + {{(ProdW-4){1'b0}}, in_item_i.char_code[3:0]};
    span_sum = {{(SumW-SpanW){1'b0}}, span_q} + {{(SumW-RUN_BITS){1'b0}}, run_q};

    run_d      = run_q;
    stop_d     = stop_q;
    span_d     = span_q;
    clip_cnt_d = clip_cnt_q;
    left_d     = left_q;
    right_d    = right_q;

    if (is_digit) begin
      if (!stop_q) begin
        run_d = (prod[ProdW-1:RUN_BITS] != '0) ? {RUN_BITS{1'b1}} : prod[RUN_BITS-1:0];
      end
    end else if (is_op) begin
      if (is_span_op) begin
        span_d = (span_sum[SumW-1:SpanW] != '0) ? {SpanW{1'b1}} : span_sum[SpanW-1:0];
      end else if (is_clip) begin
        if (clip_cnt_q == csee_pkg::CLIP_NONE) begin
          left_d = run_q;
        end else if (clip_cnt_q == csee_pkg::CLIP_LEFT) begin
          right_d = run_q;
        end
        if (clip_cnt_q != csee_pkg::CLIP_SAT) begin
          clip_cnt_d = clip_cnt_q + 2'd1;
        end
      end
      run_d  = '0;
      stop_d = 1'b0;
    end else begin
      // non-digit, non-operation: freeze digit accumulation
      stop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= '0;
      stop_q     <= 1'b0;
      span_q     <= '0;
      clip_cnt_q <= csee_pkg::CLIP_NONE;
      left_q     <= '0;
      right_q    <= '0;
    end else if (in_acc) begin
      if (in_item_i.last_char) begin
        run_q      <= '0;
        stop_q     <= 1'b0;
        span_q     <= '0;
        clip_cnt_q <= csee_pkg::CLIP_NONE;
        left_q     <= '0;
        right_q    <= '0;
      end else begin
        run_q      <= run_d;
        stop_q     <= stop_d;
        span_q     <= span_d;
        clip_cnt_q <= clip_cnt_d;
        left_q     <= left_d;
        right_q    <= right_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: snapshot of the updated state on a last character
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= a_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_pos_q   <= in_item_i.map_position;
      a_span_q  <= span_d;
      a_left_q  <= left_d;
      a_right_q <= right_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: start = pos - left, end = pos + span + right (saturated)
  // ---------------------------------------------------------------------
  always_comb begin
    start_diff = {{(EndW-PosW){1'b0}}, a_pos_q} - {{(EndW-RUN_BITS){1'b0}}, a_left_q};
    end_sum    = {{(EndW-PosW){1'b0}}, a_pos_q}
               + {{(EndW-SpanW){1'b0}}, a_span_q}
               + {{(EndW-RUN_BITS){1'b0}}, a_right_q};
    out_d.clipped_start = $signed(start_diff[CW-1:0]);
    out_d.clipped_end   = end_sum[EndW-1] ? {CW{1'b1}} : end_sum[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && a_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_ready_when_a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> in_ready_o)
    else $error("input stalled with empty stage A");

  a_state_cleared_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_load |=> (run_q == '0) && (span_q == '0) && (clip_cnt_q == csee_pkg::CLIP_NONE))
    else $error("parse state not cleared after last item");

  a_clip_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_item_i.last_char) |=> (clip_cnt_q >= $past(clip_cnt_q)))
    else $error("clip count went down within a string");

  a_stage_a_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !out_load) |=> a_valid_q && $stable(a_pos_q))
    else $error("stage A lost a result under stall");

endmodule

>>> tb/tb_cigar_soft_clip_end_extender_core.sv
// Testbench for cigar_soft_clip_end_extender_core: drives CIGAR strings one
// character per item and checks every clipped start/end against a local model.
// Depends on csee_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_cigar_soft_clip_end_extender_core;

  localparam int unsigned RUN_W       = csee_pkg::RUN_BITS_DEF;
  localparam int unsigned CHAR_W      = csee_pkg::CHAR_W;
  localparam int unsigned POS_W       = csee_pkg::POS_W;
  localparam int unsigned COORD_W     = csee_pkg::COORD_W;
  localparam int unsigned SPAN_W      = csee_pkg::SPAN_BITS;
  localparam int          ITEM_TARGET = 1350;
  // The slowest legal run stays well under this limit, leaving a wide margin.
  localparam int          CYCLE_LIMIT = 400000;

  // Operation mixes for random strings. '=' and 'A'/'Z' are not operations
  // here, they stop digit accumulation like any other stray character.
  localparam string MAIN_OPS = "MMMDDNNSSS";
  localparam string ODD_OPS  = "IHPXBY=AZmsd";

  typedef logic [CHAR_W-1:0] char_q_t[$];

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  csee_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  csee_pkg::out_item_t out_item;

  // Parse state of the local model, same widths as the block.
  logic [RUN_W-1:0]  run_len;
  bit                digits_off;
  logic [SPAN_W-1:0] span_sum;
  logic [1:0]        clip_seen;
  logic [RUN_W-1:0]  lead_clip;
  logic [RUN_W-1:0]  trail_clip;

  csee_pkg::out_item_t pending_coords[$];
  csee_pkg::out_item_t want_coords;

  int errors      = 0;
  int chars_sent  = 0;
  int cycle_count = 0;
  int hold_len    = 0;  // length of the next long sink hold
  int hold_reqs   = 0;  // bumped by a test to request one hold
  bit no_idle     = 1'b0;

  cigar_soft_clip_end_extender_core #(
    .RUN_BITS(RUN_W)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Model: one character updates the parse state; a last character also
  // yields the clipped coordinates and clears everything.
  // ---------------------------------------------------------------------------
  function automatic void clear_parse();
    run_len    = '0;
    digits_off = 1'b0;
    span_sum   = '0;
    clip_seen  = csee_pkg::CLIP_NONE;
    lead_clip  = '0;
    trail_clip = '0;
  endfunction

  function automatic void track_cigar_char(input csee_pkg::in_item_t it);
    logic [39:0]         grown;
    logic [32:0]         span_next;
    logic [33:0]         end_sum;
    csee_pkg::out_item_t coords;
    if (it.char_code >= csee_pkg::CHAR_0 && it.char_code <= csee_pkg::CHAR_9) begin
      // Digits are dropped once a stray character has stopped the run.
      if (!digits_off) begin
        grown = 40'(run_len) * 40'd10 + 40'(it.char_code - csee_pkg::CHAR_0);
        if (grown > ((40'd1 << RUN_W) - 40'd1)) run_len = '1;
        else run_len = grown[RUN_W-1:0];
      end
    end else if (it.char_code > csee_pkg::CHAR_A && it.char_code < csee_pkg::CHAR_Z) begin
      if (it.char_code == csee_pkg::CHAR_M || it.char_code == csee_pkg::CHAR_D ||
          it.char_code == csee_pkg::CHAR_N) begin
        span_next = 33'(span_sum) + 33'(run_len);
        if (span_next >= (33'd1 << SPAN_W)) span_sum = '1;
        else span_sum = span_next[SPAN_W-1:0];
      end else if (it.char_code == csee_pkg::CHAR_S) begin
        // First S is the leading clip, second the trailing one, rest dropped.
        if (clip_seen == csee_pkg::CLIP_NONE) lead_clip = run_len;
        else if (clip_seen == csee_pkg::CLIP_LEFT) trail_clip = run_len;
        if (clip_seen != csee_pkg::CLIP_SAT) clip_seen = clip_seen + 2'd1;
      end
      run_len    = '0;
      digits_off = 1'b0;
    end else begin
      digits_off = 1'b1;
    end

    if (it.last_char) begin
      coords.clipped_start = {1'b0, it.map_position} - COORD_W'(lead_clip);
      end_sum = 34'(it.map_position) + 34'(span_sum) + 34'(trail_clip);
      coords.clipped_end = (end_sum > 34'h0_FFFF_FFFF) ? '1 : end_sum[COORD_W-1:0];
      pending_coords.insert(pending_coords.size(), coords);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly short, now and then a long gap.
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return POS_W'($urandom_range(0, 1000));
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic char_q_t text(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: one item per call. Valid is only lowered when a gap follows,
  // so back-to-back items keep it high across the accept edge.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic [POS_W-1:0] pos,
                           input bit last);
    int                 gap;
    csee_pkg::in_item_t it;
    it.char_code    = c;
    it.map_position = pos;
    it.last_char    = last;
    gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_cigar_char(it);
    chars_sent++;
  endtask

  task automatic send_seq(input char_q_t seq, input logic [POS_W-1:0] pos, input bit close);
    for (int i = 0; i < seq.size(); i++)
      send_char(seq[i], pos, close && (i == seq.size() - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stalls, or one long hold when a test asks for it.
  // ---------------------------------------------------------------------------
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result check: each accepted item against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_coords.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual start=%0d end=%0d",
                 $time, out_item.clipped_start, out_item.clipped_end);
      end else begin
        want_coords = pending_coords.pop_front();
        if (out_item.clipped_start !== want_coords.clipped_start) begin
          errors++;
          $display("%0t: clipped_start expected %0d actual %0d",
                   $time, want_coords.clipped_start, out_item.clipped_start);
        end
        if (out_item.clipped_end !== want_coords.clipped_end) begin
          errors++;
          $display("%0t: clipped_end expected %0d actual %0d",
                   $time, want_coords.clipped_end, out_item.clipped_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Operation with no digits in front, lowest position.
  task automatic test_bare_operation();
    send_seq(text("M"), '0, 1'b1);
  endtask

  // Nine nines overflow the run; saturated clip against the highest position.
  task automatic test_run_saturation();
    send_seq(text("999999999S"), '1, 1'b1);
  endtask

  // Leading and trailing clip, a third S that is dropped, a stray 'A' that
  // freezes the digits until the next operation, and a 0xFF closing byte.
  // Position 1 against a clip of 3 gives a negative start.
  task automatic test_clip_order();
    send_seq(text("3SA7D2S5S"), POS_W'(1), 1'b0);
    send_char(8'hFF, POS_W'(1), 1'b1);
  endtask

  // 'B' and 'Y' are the outermost operation codes and discard their runs;
  // 'Z' stops digits without clearing the run, so N adds 2. Closes on NUL.
  task automatic test_op_boundaries();
    logic [POS_W-1:0] pos;
    pos = pick_pos();
    send_seq(text("6B1Y2Z3N"), pos, 1'b0);
    send_char(8'h00, pos, 1'b1);
  endtask

  // Mostly well-formed strings with random content; some carry stray bytes,
  // a few end on a digit, and a few saturate the reference span.
  task automatic test_random_cigars(input int count);
    char_q_t           seq;
    int                stop_at;
    int                kind;
    int                ops;
    int                ndig;
    int                r;
    logic [CHAR_W-1:0] op;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      seq.delete();
      kind = $urandom_range(0, 99);
      ops  = $urandom_range(1, 6);
      for (int k = 0; k < ops; k++) begin
        if (kind < 3) begin
          // Saturated M runs: five of them overflow the span.
          repeat (10) seq.insert(seq.size(), csee_pkg::CHAR_9);
          seq.insert(seq.size(), csee_pkg::CHAR_M);
        end else begin
          r = $urandom_range(0, 99);
          ndig = (r < 15) ? 0 :
                 (r < 80) ? $urandom_range(1, 3) :
                 (r < 95) ? $urandom_range(4, 7) : $urandom_range(8, 10);
          repeat (ndig)
            seq.insert(seq.size(), csee_pkg::CHAR_0 + CHAR_W'($urandom_range(0, 9)));
          r = $urandom_range(0, 99);
          if (r < 75)      op = MAIN_OPS[$urandom_range(0, MAIN_OPS.len() - 1)];
          else if (r < 90) op = ODD_OPS[$urandom_range(0, ODD_OPS.len() - 1)];
          else             op = CHAR_W'($urandom_range(0, 255));
          seq.insert(seq.size(), op);
          if (kind >= 90 && $urandom_range(0, 2) == 0)
            seq.insert(seq.size(), CHAR_W'($urandom_range(0, 255)));
        end
      end
      // Broken string: the last flag lands on a trailing digit.
      if (kind >= 85 && kind < 90)
        seq.insert(seq.size(), csee_pkg::CHAR_0 + CHAR_W'($urandom_range(0, 9)));
      send_seq(seq, pick_pos(), 1'b1);
    end
  endtask

  // No gaps on either side.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_cigars(150);
    no_idle = 1'b0;
  endtask

  // Sink holds off long enough that both result registers fill and the
  // input stalls while short strings keep coming.
  task automatic test_output_backpressure();
    no_idle   = 1'b1;
    hold_len  = 300;
    hold_reqs = hold_reqs + 1;
    repeat (40) send_seq(text("2M"), pick_pos(), 1'b1);
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    clear_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bare_operation();
    test_run_saturation();
    test_clip_order();
    test_op_boundaries();
    test_back_to_back();
    test_output_backpressure();
    test_random_cigars(ITEM_TARGET - chars_sent);

    in_valid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
